// ===== design/lstk_pkg.sv =====
// Shared types and constants for the LIFO stack with reverse.
// Used by lstk_core, lifo_stack_with_reverse_unit and the testbench; no dependencies.
`timescale 1ns / 1ps

package lstk_pkg;

  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned CMD_W          = 3;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned VALUE_W        = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 3'd0,
    CMD_POP     = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_REVERSE = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic    valid;
    logic    rd;
    logic    empty;
    status_e status;
  } lstk_res_t;

endpackage

// ===== design/lstk_ram.sv =====
// Single-port-write, single-port-read synchronous memory holding the stack entries.
// Read data is registered and holds its value while no read is issued. Uses no package.
`timescale 1ns / 1ps

module lstk_ram #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AW         = 6
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lstk_core.sv =====
// Pointer and count unit of the LIFO stack: ring position arithmetic, memory
// access control and the result stage. Depends on lstk_pkg.
`timescale 1ns / 1ps

module lstk_core #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned AW         = 6,
  parameter int unsigned CW         = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lstk_pkg::CMD_W-1:0]   cmd_i,
  input  logic [lstk_pkg::VALUE_W-1:0] push_value_i,
  input  logic                         res_take_i,
  output lstk_pkg::lstk_res_t          res_o,
  output logic [CW-1:0]                res_cnt_o,
  output logic                         ram_we_o,
  output logic [AW-1:0]                ram_waddr_o,
  output logic [DATA_WIDTH-1:0]        ram_wdata_o,
  output logic                         ram_re_o,
  output logic [AW-1:0]                ram_raddr_o
);
  import lstk_pkg::*;

  localparam logic [AW:0]   DEPTH_X = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [AW-1:0] base_q, base_d;
  logic          dir_q, dir_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          res_valid_q, res_rd_q, res_empty_q;
  status_e       res_status_q, status_d;
  logic [CW-1:0] res_cnt_q;

  logic          accept;
  logic          rd_d, we_d;
  logic [CW-1:0] cnt_dec;
  logic [AW-1:0] top_idx, pos;
  logic [AW:0]   up_sum, dn_diff;

  assign in_stall_o = res_valid_q && !res_take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cnt_dec = cnt_q - 1'b1;
    top_idx = (cmd_i == CMD_PUSH) ? cnt_q[AW-1:0] : cnt_dec[AW-1:0];
    up_sum  = {1'b0, base_q} + {1'b0, top_idx};
    if (up_sum >= DEPTH_X) begin
      up_sum = up_sum - DEPTH_X;
    end
    dn_diff = {1'b0, base_q} - {1'b0, top_idx};
    if (dn_diff[AW]) begin
      dn_diff = dn_diff + DEPTH_X;
    end
    pos = dir_q ? dn_diff[AW-1:0] : up_sum[AW-1:0];
  end

  always_comb begin
    base_d   = base_q;
    dir_d    = dir_q;
    cnt_d    = cnt_q;
    status_d = ST_OK;
    rd_d     = 1'b0;
    we_d     = 1'b0;
    unique case (cmd_i)
      CMD_PUSH: begin
        if (cnt_q == DEPTH_C) begin
          status_d = ST_FULL;
        end else begin
          we_d  = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          rd_d = 1'b1;
          if (cmd_i == CMD_POP) begin
            cnt_d = cnt_dec;
          end
        end
      end
      CMD_CLEAR: begin
        cnt_d = '0;
      end
      CMD_REVERSE: begin
        if (cnt_q == '0) begin
          status_d = ST_EMPTY;
        end else if (cnt_q != CW'(1)) begin
          base_d = pos;
          dir_d  = ~dir_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_we_o    = accept && we_d;
  assign ram_waddr_o = pos;
  assign ram_wdata_o = DATA_WIDTH'(push_value_i);
  assign ram_re_o    = accept && rd_d;
  assign ram_raddr_o = pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      dir_q       <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else if (accept) begin
      base_q      <= base_d;
      dir_q       <= dir_d;
      cnt_q       <= cnt_d;
      res_valid_q <= 1'b1;
    end else if (res_take_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_status_q <= status_d;
      res_rd_q     <= rd_d;
      res_empty_q  <= (cnt_d == '0);
      res_cnt_q    <= cnt_d;
    end
  end

  assign res_o.valid  = res_valid_q;
  assign res_o.rd     = res_rd_q;
  assign res_o.empty  = res_empty_q;
  assign res_o.status = res_status_q;
  assign res_cnt_o    = res_cnt_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("entry count exceeds depth");

  a_base_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, base_q} < DEPTH_X)
    else $error("base position outside the ring");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd_i == CMD_POP) && (cnt_q == '0) |=> (cnt_q == '0) && !res_rd_q)
    else $error("pop on an empty stack changed state");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_take_i |=> res_valid_q && $stable(res_cnt_q))
    else $error("pending result lost before transfer");
`endif

endmodule

// ===== design/lifo_stack_with_reverse_unit.sv =====
// Top level of the LIFO stack with reverse: entry memory, pointer unit and output register.
// Depends on lstk_pkg, lstk_ram and lstk_core.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+-------------------------------------------
//   in      | input     | in_valid_i/in_stall_o   | cmd_i, push_value_i
//   out     | output    | out_valid_o/out_stall_i | status_o, data_out_o, stack_count_o, is_empty_o
//
// One command is taken per cycle while the result stage can drain; its result is registered in
// the result stage, beside the registered memory read, and then in the output register.
// A pop or peek reads the top entry from the memory; a push writes it in the transfer cycle,
// so a read in the following cycle already sees the new word.
// Reset clears count, base and direction; the entry memory is not cleared.
// A stalled output holds one result and a second waits in the result stage before the
// input channel stalls.
`timescale 1ns / 1ps

module lifo_stack_with_reverse_unit #(
  parameter int unsigned DEPTH      = lstk_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = lstk_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(DEPTH),
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lstk_pkg::CMD_W-1:0]    cmd_i,
  input  logic [lstk_pkg::VALUE_W-1:0]  push_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lstk_pkg::STATUS_W-1:0] status_o,
  output logic [lstk_pkg::VALUE_W-1:0]  data_out_o,
  output logic [CW-1:0]                 stack_count_o,
  output logic                          is_empty_o
);
  import lstk_pkg::*;

  lstk_res_t             res;
  logic [CW-1:0]         res_cnt;
  logic                  res_take;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [VALUE_W-1:0]    out_data_q;
  logic [CW-1:0]         out_cnt_q;
  logic                  out_empty_q;

  assign res_take = res.valid && (!out_valid_q || !out_stall_i);

  lstk_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .push_value_i (push_value_i),
    .res_take_i   (res_take),
    .res_o        (res),
    .res_cnt_o    (res_cnt),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr)
  );

  lstk_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_status_q <= res.status;
      out_data_q   <= res.rd ? VALUE_W'(ram_rdata) : '0;
      out_cnt_q    <= res_cnt;
      out_empty_q  <= res.empty;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign data_out_o    = out_data_q;
  assign stack_count_o = out_cnt_q;
  assign is_empty_o    = out_empty_q;

`ifndef SYNTHESIS
  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> out_valid_q)
    else $error("result transfer did not fill the output register");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_empty_q == (out_cnt_q == '0)))
    else $error("empty flag disagrees with count");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != ST_OK) |-> (out_data_q == '0))
    else $error("data returned with a failing status");
`endif

endmodule

// ===== test/lifo_stack_with_reverse_unit_tb.sv =====
// Self-checking testbench for lifo_stack_with_reverse_unit: a queue-fed driver, a receiver with
// random stalls and a stack predictor that checks every result transfer.
// Depends on lstk_pkg and the design sources only.
`timescale 1ns / 1ps

module lifo_stack_with_reverse_unit_tb;
  import lstk_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned IDLE_PCT     = 20;
  localparam int unsigned QUIET_FROM   = 900;
  localparam int unsigned QUIET_TO     = 1150;
  localparam int unsigned HOLD_AT      = 500;
  localparam int unsigned HOLD_CYCLES  = 120;

  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic [VALUE_W-1:0] word;
    logic               drain;
  } stack_cmd_t;

  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] data;
    logic [CW-1:0]      count;
    logic               empty;
  } stack_result_t;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [CMD_W-1:0]    cmd_i        = '0;
  logic [VALUE_W-1:0]  push_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [VALUE_W-1:0]  data_out_o;
  logic [CW-1:0]       stack_count_o;
  logic                is_empty_o;

  stack_cmd_t    cmd_queue[$];
  stack_result_t pending_results[$];

  logic [VALUE_W-1:0] shadow_words [DEPTH];
  logic [AW-1:0]      shadow_base  = '0;
  logic               shadow_down  = 1'b0;
  logic [CW-1:0]      shadow_count = '0;

  logic        in_taken    = 1'b0;
  int unsigned taken_total = 0;
  int unsigned hold_left   = 0;
  logic        hold_done   = 1'b0;
  int unsigned error_count = 0;

  lifo_stack_with_reverse_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .push_value_i  (push_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .data_out_o    (data_out_o),
    .stack_count_o (stack_count_o),
    .is_empty_o    (is_empty_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [AW-1:0] ring_slot(logic [CW-1:0] idx);
    return shadow_down ? shadow_base - idx[AW-1:0] : shadow_base + idx[AW-1:0];
  endfunction

  function automatic stack_result_t stack_predict(logic [CMD_W-1:0] op, logic [VALUE_W-1:0] word);
    stack_result_t res;
    res.status = ST_OK;
    res.data   = '0;
    case (op)
      CMD_PUSH: begin
        if (shadow_count == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[ring_slot(shadow_count)] = word;
          shadow_count = shadow_count + 1'b1;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = shadow_words[ring_slot(shadow_count - 1'b1)];
          if (op == CMD_POP) shadow_count = shadow_count - 1'b1;
        end
      end
      CMD_CLEAR: shadow_count = '0;
      CMD_REVERSE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (shadow_count > 1) begin
          shadow_base = ring_slot(shadow_count - 1'b1);
          shadow_down = ~shadow_down;
        end
      end
      default: ;
    endcase
    res.count = shadow_count;
    res.empty = (shadow_count == 0);
    return res;
  endfunction

  function automatic logic [CMD_W-1:0] pick_op(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return CMD_PUSH;
    if (r < push_pct + 12) return CMD_PEEK;
    if (r < push_pct + 22) return CMD_REVERSE;
    if (r < push_pct + 24) return CMD_CLEAR;
    if (r < push_pct + 27) begin
      return CMD_W'(CMD_UNUSED_LO + $urandom_range(0, CMD_UNUSED_HI - CMD_UNUSED_LO));
    end
    return CMD_POP;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_cmd(logic [CMD_W-1:0] op, logic [VALUE_W-1:0] word, logic drain = 1'b0);
    cmd_queue.push_back('{op: op, word: word, drain: drain});
  endtask

  task automatic add_fill_run();
    repeat (DEPTH + 2) add_cmd(CMD_PUSH, pick_word());
    add_cmd(CMD_REVERSE, pick_word());
    add_cmd(CMD_PEEK, pick_word());
    repeat (30) add_cmd(CMD_POP, pick_word());
    add_cmd(CMD_REVERSE, pick_word());
    repeat (DEPTH - 28) add_cmd(CMD_POP, pick_word());
  endtask

  initial begin
    int unsigned push_pct;
    add_cmd(CMD_POP, 32'h1234_5678);
    add_cmd(CMD_PEEK, '1);
    add_cmd(CMD_REVERSE, '0);
    add_cmd(CMD_UNUSED_LO, '1);
    add_cmd(CMD_UNUSED_LO + 1'b1, '0);
    add_cmd(CMD_UNUSED_HI, 32'hDEAD_BEEF);
    add_cmd(CMD_PUSH, '0);
    add_cmd(CMD_REVERSE, '1);
    add_cmd(CMD_PEEK, '0);
    add_cmd(CMD_PUSH, '1);
    add_cmd(CMD_PUSH, 32'hA5A5_5A5A);
    add_cmd(CMD_PUSH, 32'h0000_0001);
    add_cmd(CMD_REVERSE, '0);
    add_cmd(CMD_PEEK, '0);
    add_cmd(CMD_POP, '0);
    add_cmd(CMD_POP, '0);
    add_cmd(CMD_REVERSE, '0);
    add_cmd(CMD_POP, '0);
    add_cmd(CMD_POP, '0);
    add_cmd(CMD_POP, '0);
    add_cmd(CMD_PUSH, 32'h8000_0000);
    add_cmd(CMD_CLEAR, '1);
    add_cmd(CMD_PEEK, '0);
    add_cmd(CMD_PUSH, 32'h0000_0007, 1'b1);
    add_fill_run();
    while (cmd_queue.size() < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       add_fill_run();
        1, 2:    push_pct = 70;
        3, 4:    push_pct = 25;
        default: push_pct = 45;
      endcase
      repeat (40) add_cmd(pick_op(push_pct), pick_word());
      if (cmd_queue.size() > 700 && cmd_queue.size() < 750) cmd_queue[$].drain = 1'b1;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_queue.size() != 0 || in_valid_i || pending_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("lifo_stack_with_reverse_unit_tb: PASS");
    end else begin
      $display("lifo_stack_with_reverse_unit_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("lifo_stack_with_reverse_unit_tb: FAIL");
    $finish;
  end

  // The driver advances only once the previous transfer has happened, so a stalled
  // command stays on the pins unchanged.
  always @(negedge clk_i) begin : drive_commands
    stack_cmd_t item;
    logic       quiet;
    quiet = taken_total >= QUIET_FROM && taken_total < QUIET_TO;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (cmd_queue.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (cmd_queue[0].drain && pending_results.size() != 0) begin
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
      end else begin
        item = cmd_queue.pop_front();
        in_valid_i   <= 1'b1;
        cmd_i        <= item.op;
        push_value_i <= item.word;
      end
    end
  end

  // The long hold-off lets the block fill up and stall its input while commands keep coming.
  always @(negedge clk_i) begin : drive_stall
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && taken_total >= HOLD_AT) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else if (taken_total >= QUIET_FROM && taken_total < QUIET_TO) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin : check_results
    stack_result_t exp_res;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(stack_predict(cmd_i, push_value_i));
        taken_total <= taken_total + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: status %0d, data_out %h, stack_count %0d",
                 status_o, data_out_o, stack_count_o);
          error_count = error_count + 1;
        end else begin
          exp_res = pending_results.pop_front();
          if (status_o !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, status_o);
            error_count = error_count + 1;
          end
          if (data_out_o !== exp_res.data) begin
            $error("data_out: expected %h, actual %h", exp_res.data, data_out_o);
            error_count = error_count + 1;
          end
          if (stack_count_o !== exp_res.count) begin
            $error("stack_count: expected %0d, actual %0d", exp_res.count, stack_count_o);
            error_count = error_count + 1;
          end
          if (is_empty_o !== exp_res.empty) begin
            $error("is_empty: expected %0d, actual %0d", exp_res.empty, is_empty_o);
            error_count = error_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim.f =====
design/lstk_pkg.sv
design/lstk_ram.sv
design/lstk_core.sv
design/lifo_stack_with_reverse_unit.sv
test/lifo_stack_with_reverse_unit_tb.sv
